/* rtl/hsrt_pkg.sv */
// Shared types, codes and sizes for the hashed search result table.
// No dependencies; every other file in rtl except hsrt_ram imports this package.
`timescale 1ns / 1ps

package hsrt_pkg;

  // Table geometry (slot count must be a power of two)
  localparam int ENTRIES     = 1024;
  localparam int SLOT_W      = $clog2(ENTRIES);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef logic [SLOT_W-1:0] slot_t;

  localparam slot_t SWEEP_LAST = slot_t'(ENTRIES - 1);

  // Item kinds
  localparam logic [1:0] KIND_PROBE = 2'd0;
  localparam logic [1:0] KIND_STORE = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Bound classes held with each entry
  localparam logic [1:0] SCORE_EXACT    = 2'd0;
  localparam logic [1:0] SCORE_AT_LEAST = 2'd1;
  localparam logic [1:0] SCORE_AT_MOST  = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [63:0]        hash;
    logic [7:0]         depth;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic signed [15:0] score;
    logic [15:0]        move;
  } req_t;

  typedef struct packed {
    logic               key_match;
    logic               cutoff;
    logic signed [15:0] result_score;
    logic [15:0]        result_move;
  } rsp_t;

  // Classified item as it travels from front to back
  typedef struct packed {
    logic [1:0]         kind;
    logic [63:0]        hash;
    logic [7:0]         depth;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic signed [15:0] score;
    logic [15:0]        move;
    logic [1:0]         bound;
  } cmd_t;

  // Per-slot info word
  typedef struct packed {
    logic               valid;
    logic [1:0]         bound;
    logic [7:0]         depth;
    logic signed [15:0] score;
    logic [15:0]        move;
  } info_t;

  typedef enum logic [1:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_LOOKUP
  } back_state_t;

  // Slot index: low bits of the hash
  function automatic slot_t slot_of(input logic [63:0] hash);
    return hash[SLOT_W-1:0];
  endfunction

endpackage

/* rtl/hashed_search_result_table_unit.sv */
// Hashed search result table: direct-mapped, always-replace, ENTRIES slots.
// Throughput: one store per cycle while results are taken; a probe holds the back end
// in a lookup state for the registered RAM read, and a clear occupies the back end for a
// full clearing pass while the queue keeps filling. Reset: a clearing pass runs with
// req_ready low, then all slots are invalid.
`timescale 1ns / 1ps

module hashed_search_result_table_unit
  import hsrt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic accept_ok;
  logic q_full;
  logic q_push;
  cmd_t q_wdata;
  logic q_pop;
  logic q_valid;
  cmd_t q_rdata;

  hsrt_front u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .accept_ok (accept_ok),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  hsrt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  hsrt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .accept_ok (accept_ok),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

/* rtl/hsrt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hsrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/hsrt_front.sv */
// Front end: takes request transfers and classifies the bound of stores.
// Depends on hsrt_pkg.
`timescale 1ns / 1ps

module hsrt_front
  import hsrt_pkg::*;
(
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  input  logic accept_ok,
  input  logic q_full,
  output logic q_push,
  output cmd_t q_wdata
);

  logic [1:0] bound;

  // Classify: lower if score reaches beta, upper if at or below alpha
  always_comb begin
    if (req.score >= req.beta) begin
      bound = SCORE_AT_LEAST;
    end else if (req.score <= req.alpha) begin
      bound = SCORE_AT_MOST;
    end else begin
      bound = SCORE_EXACT;
    end
  end

  // Push into the queue on each transfer
  assign req_ready = accept_ok && !q_full;
  assign q_push    = req_valid && req_ready;

  always_comb begin
    q_wdata.kind  = req.kind;
    q_wdata.hash  = req.hash;
    q_wdata.depth = req.depth;
    q_wdata.alpha = req.alpha;
    q_wdata.beta  = req.beta;
    q_wdata.score = req.score;
    q_wdata.move  = req.move;
    q_wdata.bound = bound;
  end

endmodule

/* rtl/hsrt_queue.sv */
// Short FIFO of classified items between front and back.
// Depends on hsrt_pkg.
`timescale 1ns / 1ps

module hsrt_queue
  import hsrt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t rdata
);

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign rdata = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Hold item payloads
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

/* rtl/hsrt_back.sv */
// Back end: carries out probes, stores and clears against the key and info RAMs.
// Depends on hsrt_pkg and hsrt_ram.
`timescale 1ns / 1ps

module hsrt_back
  import hsrt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_rdata,
  output logic q_pop,
  output logic accept_ok,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  back_state_t state;
  back_state_t state_next;
  slot_t       sweep_addr;
  logic        sweep_reply;
  cmd_t        cur;
  logic        out_valid;
  rsp_t        out_data;

  logic        key_we;
  logic [63:0] key_rdata;
  logic        info_we;
  slot_t       info_waddr;
  info_t       info_wdata;
  info_t       info_rdata;
  slot_t       raddr;
  logic        load;
  rsp_t        load_data;
  logic        hit;
  logic        fits;
  rsp_t        probe_rsp;

  assign raddr = slot_of(q_rdata.hash);

  hsrt_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (raddr),
    .wdata (q_rdata.hash),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  hsrt_ram #(.WIDTH($bits(info_t)), .DEPTH(ENTRIES)) u_info_ram (
    .clk   (clk),
    .we    (info_we),
    .waddr (info_waddr),
    .wdata (info_wdata),
    .raddr (raddr),
    .rdata (info_rdata)
  );

  // Take the next item once the result register is free or being freed
  assign q_pop     = (state == BK_IDLE) && q_valid && (!out_valid || rsp_ready);
  // Hold off new transfers only during the clearing pass after reset
  assign accept_ok = !((state == BK_SWEEP) && !sweep_reply);

  // Probe evaluation on the registered read data
  always_comb begin
    hit  = info_rdata.valid && (key_rdata == cur.hash);
    fits = (info_rdata.bound == SCORE_EXACT)
        || ((info_rdata.bound == SCORE_AT_LEAST) && (info_rdata.score >= cur.beta))
        || ((info_rdata.bound == SCORE_AT_MOST) && (info_rdata.score <= cur.alpha));
    probe_rsp              = '0;
    probe_rsp.key_match    = hit;
    probe_rsp.result_move  = hit ? info_rdata.move : '0;
    probe_rsp.cutoff       = hit && (info_rdata.depth >= cur.depth) && fits;
    probe_rsp.result_score = probe_rsp.cutoff ? info_rdata.score : '0;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_SWEEP: begin
        if (sweep_addr == SWEEP_LAST) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_pop) begin
          case (q_rdata.kind)
            KIND_PROBE: state_next = BK_LOOKUP;
            KIND_CLEAR: state_next = BK_SWEEP;
            default:    state_next = BK_IDLE;
          endcase
        end
      end
      BK_LOOKUP: state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  // Memory controls and result loading
  always_comb begin
    key_we           = 1'b0;
    info_we          = 1'b0;
    info_waddr       = raddr;
    info_wdata       = '0;
    info_wdata.valid = 1'b1;
    info_wdata.bound = q_rdata.bound;
    info_wdata.depth = q_rdata.depth;
    info_wdata.score = q_rdata.score;
    info_wdata.move  = q_rdata.move;
    load             = 1'b0;
    load_data        = '0;
    case (state)
      BK_SWEEP: begin
        info_we    = 1'b1;
        info_waddr = sweep_addr;
        info_wdata = '0;
        load       = (sweep_addr == SWEEP_LAST) && sweep_reply;
      end
      BK_IDLE: begin
        if (q_pop) begin
          case (q_rdata.kind)
            KIND_PROBE: load = 1'b0;
            KIND_STORE: begin
              key_we  = 1'b1;
              info_we = 1'b1;
              load    = 1'b1;
            end
            KIND_CLEAR: load = 1'b0;
            default:    load = 1'b1;
          endcase
        end
      end
      BK_LOOKUP: begin
        load      = 1'b1;
        load_data = probe_rsp;
      end
      default: load = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_SWEEP;
      sweep_addr  <= '0;
      sweep_reply <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_SWEEP) begin
        sweep_addr <= sweep_addr + 1'b1;
      end
      if (q_pop && (q_rdata.kind == KIND_CLEAR)) begin
        sweep_addr  <= '0;
        sweep_reply <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_rdata;
    end
    if (load) begin
      out_data <= load_data;
    end
  end

  assign rsp_valid = out_valid;
  assign rsp       = out_data;

  // Result register must be empty when a lookup completes
  a_lookup_free: assert property (@(posedge clk) disable iff (rst)
    (state == BK_LOOKUP) |-> !out_valid)
    else $error("lookup completing with result register occupied");

  a_lookup_result: assert property (@(posedge clk) disable iff (rst)
    (state == BK_LOOKUP) |=> out_valid)
    else $error("lookup produced no result");

  a_sweep_clears: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SWEEP) |-> (info_we && !info_wdata.valid && !key_we))
    else $error("sweep not invalidating slot");

  a_store_pair: assert property (@(posedge clk) disable iff (rst)
    key_we |-> (info_we && info_wdata.valid && (info_waddr == raddr)))
    else $error("key write without matching info write");

endmodule

/* tb/sv/hsrt_checker.sv */
// Scoreboard for the hashed search result table: watches both channels,
// keeps its own copy of the table and compares every result transfer.
// Depends on hsrt_pkg for the payload types, kinds, bounds and table size.
`timescale 1ns / 1ps

module hsrt_checker
  import hsrt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending
);

  // Shadow copy of every slot
  logic [63:0]        shadow_key   [ENTRIES];
  logic               shadow_live  [ENTRIES];
  logic [1:0]         shadow_bound [ENTRIES];
  logic [7:0]         shadow_depth [ENTRIES];
  logic signed [15:0] shadow_score [ENTRIES];
  logic [15:0]        shadow_move  [ENTRIES];

  rsp_t lookup_q[$];
  rsp_t want;
  int   errors = 0;

  function automatic void wipe_shadow();
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_live[i] = 1'b0;
    end
  endfunction

  // Apply one request to the shadow table and work out its result
  function automatic rsp_t table_access(input req_t r);
    rsp_t        res;
    int unsigned s;
    logic        usable;
    res    = '0;
    usable = 1'b0;
    s      = int'(r.hash[SLOT_W-1:0]);
    case (r.kind)
      KIND_PROBE: begin
        if (shadow_live[s] && shadow_key[s] == r.hash) begin
          res.key_match   = 1'b1;
          res.result_move = shadow_move[s];
          if (shadow_depth[s] >= r.depth) begin
            case (shadow_bound[s])
              SCORE_EXACT:    usable = 1'b1;
              SCORE_AT_LEAST: usable = (shadow_score[s] >= r.beta);
              SCORE_AT_MOST:  usable = (shadow_score[s] <= r.alpha);
              default:        usable = 1'b0;
            endcase
          end
          if (usable) begin
            res.cutoff       = 1'b1;
            res.result_score = shadow_score[s];
          end
        end
      end
      KIND_STORE: begin
        if (r.score >= r.beta) begin
          shadow_bound[s] = SCORE_AT_LEAST;
        end else if (r.score <= r.alpha) begin
          shadow_bound[s] = SCORE_AT_MOST;
        end else begin
          shadow_bound[s] = SCORE_EXACT;
        end
        shadow_key[s]   = r.hash;
        shadow_live[s]  = 1'b1;
        shadow_depth[s] = r.depth;
        shadow_score[s] = r.score;
        shadow_move[s]  = r.move;
      end
      KIND_CLEAR: wipe_shadow();
      default: ;
    endcase
    return res;
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, got_v);
      errors++;
    end
  endfunction

  // Predict on each request transfer, compare on each result transfer
  always @(posedge clk) begin
    if (rst) begin
      wipe_shadow();
      lookup_q.delete();
    end else begin
      if (req_valid && req_ready) begin
        lookup_q.push_back(table_access(req));
      end
      if (rsp_valid && rsp_ready) begin
        if (lookup_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          errors++;
        end else begin
          want = lookup_q.pop_front();
          compare_field("key_match", 16'(want.key_match), 16'(rsp.key_match));
          compare_field("cutoff", 16'(want.cutoff), 16'(rsp.cutoff));
          compare_field("result_score", want.result_score, rsp.result_score);
          compare_field("result_move", want.result_move, rsp.result_move);
        end
      end
    end
    pending    <= lookup_q.size();
    fail_count <= errors;
  end

endmodule

/* tb/sv/tb_top.sv */
// Top of the hashed search result table bench: clock, reset, request stimulus,
// random result back-pressure, stall watchdog and verdict.
// Depends on hsrt_pkg, hashed_search_result_table_unit and hsrt_checker.
`timescale 1ns / 1ps

module tb_top;
  import hsrt_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4 * ENTRIES + 1000;
  localparam int PHASE_ITEMS = 165;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int fail_count;
  int pending;
  int send_idle = 13;
  int rcv_idle = 45;
  int idle_cycles = 0;

  logic [63:0] key_pool [16];

  always #1 clk = ~clk;

  hashed_search_result_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  hsrt_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Throttle the result side at random
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  // Abort when no transfer happens on either side for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic req_t make_req(input logic [1:0] kind, input logic [63:0] hash,
                                    input logic [7:0] depth, input logic signed [15:0] alpha,
                                    input logic signed [15:0] beta,
                                    input logic signed [15:0] score, input logic [15:0] move);
    req_t r;
    r.kind  = kind;
    r.hash  = hash;
    r.depth = depth;
    r.alpha = alpha;
    r.beta  = beta;
    r.score = score;
    r.move  = move;
    return r;
  endfunction

  // Score-like value, biased towards the extremes and zero
  function automatic logic signed [15:0] rand_score();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Fresh pool key, sometimes sharing a slot with another pool key
  function automatic logic [63:0] fresh_key();
    logic [63:0] h;
    h = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) begin
      h[SLOT_W-1:0] = key_pool[$urandom_range(0, 15)][SLOT_W-1:0];
    end
    return h;
  endfunction

  // Hold the request until the transfer, with random gaps in front of it
  task automatic send(input req_t item);
    while ($urandom_range(0, 99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
  endtask

  // Hold off the sender until every outstanding result has arrived
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] KEY_A    = 64'h8000_0000_0000_0155;
  localparam logic [63:0] KEY_B    = 64'h7fff_0000_a5a5_02aa;
  localparam logic [63:0] KEY_C    = 64'h0123_4567_89ab_cdef;
  localparam logic [63:0] KEY_D    = 64'h5555_aaaa_5555_a3c7;

  initial begin
    logic [63:0] h;
    int          pick;
    logic [1:0]  kind;

    for (int i = 0; i < 16; i++) begin
      key_pool[i] = {$urandom, $urandom};
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, all bound kinds, aliasing, overwrite, unused kind, clear
    send(make_req(KIND_PROBE, 64'h0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'h0));
    send(make_req(KIND_PROBE, ALL_ONES, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'h0));
    send(make_req(KIND_STORE, 64'h0, 8'd0, -16'sd10, 16'sd10, 16'sd0, 16'h0));
    send(make_req(KIND_PROBE, 64'h0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'h0));
    send(make_req(KIND_PROBE, 64'(ENTRIES), 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'h0));
    send(make_req(KIND_STORE, ALL_ONES, 8'd255, 16'sh8000, 16'sh8000, 16'sh7fff, 16'hffff));
    send(make_req(KIND_PROBE, ALL_ONES, 8'd255, 16'sh8000, 16'sh7fff, 16'sd0, 16'h0));
    send(make_req(KIND_STORE, KEY_A, 8'd10, -16'sd100, 16'sd50, 16'sd60, 16'h0a0a));
    send(make_req(KIND_PROBE, KEY_A, 8'd10, 16'sd0, 16'sd60, 16'sd0, 16'h0));
    send(make_req(KIND_PROBE, KEY_A, 8'd10, 16'sd0, 16'sd61, 16'sd0, 16'h0));
    send(make_req(KIND_PROBE, KEY_A, 8'd11, 16'sd0, 16'sd0, 16'sd0, 16'h0));
    send(make_req(KIND_STORE, KEY_B, 8'd7, 16'sd0, 16'sd100, 16'sh8000, 16'h8001));
    send(make_req(KIND_PROBE, KEY_B, 8'd7, 16'sh8000, 16'sd0, 16'sd0, 16'h0));
    send(make_req(KIND_STORE, KEY_C, 8'd3, -16'sd5, 16'sd100, -16'sd5, 16'h1357));
    send(make_req(KIND_PROBE, KEY_C, 8'd0, -16'sd6, 16'sd0, 16'sd0, 16'h0));
    send(make_req(KIND_PROBE, KEY_C, 8'd0, -16'sd5, 16'sd0, 16'sd0, 16'h0));
    send(make_req(KIND_STORE, KEY_D, 8'd1, 16'sd100, -16'sd100, 16'sd0, 16'h2468));
    send(make_req(KIND_PROBE, KEY_D, 8'd1, 16'sd100, -16'sd100, 16'sd0, 16'h0));
    send(make_req(KIND_STORE, KEY_A, 8'd0, -16'sd1, 16'sd1, 16'sd0, 16'h1234));
    send(make_req(KIND_PROBE, KEY_A, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'h0));
    send(make_req(KIND_UNUSED, KEY_A, 8'd255, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'hffff));
    send(make_req(KIND_PROBE, KEY_A, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'h0));
    send(make_req(KIND_CLEAR, ALL_ONES, 8'd255, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff));
    send(make_req(KIND_PROBE, 64'h0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'h0));
    send(make_req(KIND_PROBE, KEY_A, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'h0));
    drain();

    // Random: stores and probes on a small key pool, rare clears and unused kinds
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 13; rcv_idle = 45; end
        1: begin send_idle = 45; rcv_idle = 13; end
        default: begin send_idle = 0; rcv_idle = 0; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 30 == 29) begin
          key_pool[$urandom_range(0, 15)] = fresh_key();
        end
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          kind = KIND_CLEAR;
        end else if (pick < 5) begin
          kind = KIND_UNUSED;
        end else if (pick < 50) begin
          kind = KIND_STORE;
        end else begin
          kind = KIND_PROBE;
        end
        h = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                         : key_pool[$urandom_range(0, 15)];
        send(make_req(kind, h, 8'($urandom_range(0, 255)), rand_score(), rand_score(),
                      rand_score(), 16'($urandom)));
        if (i == PHASE_ITEMS / 2) begin
          drain();
        end
      end
      drain();
    end

    // Let any stray result show up before the verdict
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/hsrt_pkg.sv
rtl/hsrt_ram.sv
rtl/hsrt_front.sv
rtl/hsrt_queue.sv
rtl/hsrt_back.sv
rtl/hashed_search_result_table_unit.sv
tb/sv/hsrt_checker.sv
tb/sv/tb_top.sv
